>>> rtl/core/c2s_pkg.sv
package c2s_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int ANGLE_WIDTH  = 16;
   localparam int RADIUS_WIDTH = 24;

   // square-root unit: 64-bit radicand, one result bit per stage
   localparam int SQ_IN_W = 64;
   localparam int ROOT_W  = SQ_IN_W / 2;
   localparam int REM_W   = ROOT_W + 3;

   // angle unit: signed datapath, operands normalized to [2^58, 2^59)
   localparam int COR_W        = 62;
   localparam int NORM_TOP     = 59;
   localparam int NORM_STEPS   = 6;
   localparam int CORDIC_STEPS = 31;
   localparam int BAM_W        = 32;

   // prescale of x^2+y^2 by 4^k, k found in five binary steps
   localparam int SCALE_STEPS = 5;

   localparam int FRONT_LAT = 2 + SCALE_STEPS;
   localparam int SQRT_LAT  = ROOT_W;
   localparam int COR_LAT   = 2 + NORM_STEPS + CORDIC_STEPS + 1;
   localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + COR_LAT;

   // atan(2^-i) in units of pi/2^31
   localparam logic [BAM_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
      32'd1
   };

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_Z_AXIS = 2'd1,
      STAT_ORIGIN = 2'd2
   } status_type;

   typedef logic signed [COR_W-1:0]  cor_word_type;
   typedef logic [ANGLE_WIDTH-1:0]   angle_type;
   typedef logic [SQ_IN_W-1:0]       radicand_type;
   typedef logic [ROOT_W-1:0]        root_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } tag_type;

endpackage

>>> rtl/core/c2s_front.sv
module c2s_front (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic signed [c2s_pkg::COORD_WIDTH-1:0] x_coord,
   input  logic signed [c2s_pkg::COORD_WIDTH-1:0] y_coord,
   input  logic signed [c2s_pkg::COORD_WIDTH-1:0] z_coord,
   output c2s_pkg::radicand_type                 sum_sq,
   output c2s_pkg::radicand_type                 scaled_sxy,
   output c2s_pkg::cor_word_type                 scaled_z
);
   import c2s_pkg::*;

   localparam int PROD_W = 2 * COORD_WIDTH;
   localparam int SUM_W  = PROD_W + 2;

   logic signed [PROD_W-1:0] sx_in, sy_in, sz_in;
   logic [PROD_W-1:0]        sx_ff, sy_ff, sz_ff;
   logic signed [COORD_WIDTH-1:0] z1_ff;

   radicand_type s_ff   [SCALE_STEPS+1];
   radicand_type tot_ff [SCALE_STEPS+1];
   cor_word_type zs_ff  [SCALE_STEPS+1];

   assign sx_in = x_coord * x_coord;
   assign sy_in = y_coord * y_coord;
   assign sz_in = z_coord * z_coord;

   always_ff @(posedge clock) begin
      if (advance) begin
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         sz_ff     <= sz_in;
         z1_ff     <= z_coord;
         s_ff[0]   <= SQ_IN_W'({1'b0, sx_ff} + {1'b0, sy_ff});
         tot_ff[0] <= SQ_IN_W'(SUM_W'(sx_ff) + SUM_W'(sy_ff) + SUM_W'(sz_ff));
         zs_ff[0]  <= COR_W'(z1_ff);
      end
   end

   // greedy 4^k prescale: 16, 8, 4, 2, 1 -> result lands in [2^62, 2^64)
   for (genvar j = 0; j < SCALE_STEPS; j++) begin : g_scale
      localparam int SH = 1 << (SCALE_STEPS - 1 - j);
      logic do_shift;
      assign do_shift = (s_ff[j][SQ_IN_W-1 -: 2*SH] == '0);
      always_ff @(posedge clock) begin
         if (advance) begin
            s_ff[j+1]   <= do_shift ? (s_ff[j] << (2*SH)) : s_ff[j];
            zs_ff[j+1]  <= do_shift ? (zs_ff[j] <<< SH) : zs_ff[j];
            tot_ff[j+1] <= tot_ff[j];
         end
      end
   end

   assign sum_sq     = tot_ff[SCALE_STEPS];
   assign scaled_sxy = s_ff[SCALE_STEPS];
   assign scaled_z   = zs_ff[SCALE_STEPS];

endmodule

>>> rtl/core/c2s_isqrt.sv
module c2s_isqrt (
   input  logic                  clock,
   input  logic                  advance,
   input  c2s_pkg::radicand_type radicand,
   output c2s_pkg::root_type     root
);
   import c2s_pkg::*;

   radicand_type          rad_ff  [ROOT_W];
   logic [REM_W-1:0]      rem_ff  [ROOT_W];
   root_type              root_ff [ROOT_W];

   // restoring square root, one root bit per stage
   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      radicand_type     rad_d;
      logic [REM_W-1:0] rem_d, rem_sh, trial;
      root_type         root_d;
      logic             ge;

      if (i == 0) begin : g_first
         assign rad_d  = radicand;
         assign rem_d  = '0;
         assign root_d = '0;
      end else begin : g_next
         assign rad_d  = rad_ff[i-1];
         assign rem_d  = rem_ff[i-1];
         assign root_d = root_ff[i-1];
      end

      assign rem_sh = {rem_d[REM_W-3:0], rad_d[SQ_IN_W-1 -: 2]};
      assign trial  = REM_W'({root_d, 2'b01});
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (advance) begin
            rad_ff[i]  <= rad_d << 2;
            rem_ff[i]  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff[i] <= {root_d[ROOT_W-2:0], ge};
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

>>> rtl/core/c2s_cordic.sv
module c2s_cordic (
   input  logic                  clock,
   input  logic                  advance,
   input  c2s_pkg::cor_word_type num,
   input  c2s_pkg::cor_word_type den,
   output c2s_pkg::angle_type    angle
);
   import c2s_pkg::*;

   localparam int RND_SH = BAM_W - ANGLE_WIDTH;

   // fold into right half plane
   cor_word_type xa_ff, ya_ff;
   logic         base_a_ff;

   // magnitude bound and normalization
   cor_word_type       nx_ff [NORM_STEPS+1];
   cor_word_type       ny_ff [NORM_STEPS+1];
   logic [COR_W-1:0]   nm_ff [NORM_STEPS+1];
   logic               nb_ff [NORM_STEPS+1];

   cor_word_type       cx_ff [CORDIC_STEPS];
   cor_word_type       cy_ff [CORDIC_STEPS];
   logic [BAM_W-1:0]   cz_ff [CORDIC_STEPS];
   logic               cb_ff [CORDIC_STEPS];

   angle_type          angle_ff;

   cor_word_type     ymag_in;
   logic [BAM_W-1:0] bam_in, rnd_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         base_a_ff <= den[COR_W-1];
         xa_ff     <= den[COR_W-1] ? -den : den;
         ya_ff     <= den[COR_W-1] ? -num : num;
      end
   end

   assign ymag_in = ya_ff[COR_W-1] ? -ya_ff : ya_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff[0] <= xa_ff;
         ny_ff[0] <= ya_ff;
         nm_ff[0] <= (xa_ff > ymag_in) ? xa_ff : ymag_in;
         nb_ff[0] <= base_a_ff;
      end
   end

   // left shifts by 32..1 until the larger magnitude reaches 2^58
   for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
      localparam int SH = 1 << (NORM_STEPS - 1 - j);
      logic do_shift;
      assign do_shift = (nm_ff[j][COR_W-1:NORM_TOP-SH] == '0);
      always_ff @(posedge clock) begin
         if (advance) begin
            nx_ff[j+1] <= do_shift ? (nx_ff[j] <<< SH) : nx_ff[j];
            ny_ff[j+1] <= do_shift ? (ny_ff[j] <<< SH) : ny_ff[j];
            nm_ff[j+1] <= do_shift ? (nm_ff[j] << SH) : nm_ff[j];
            nb_ff[j+1] <= nb_ff[j];
         end
      end
   end

   // vectoring iterations, one per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      cor_word_type     x_d, y_d;
      logic [BAM_W-1:0] z_d;
      logic             b_d;

      if (i == 0) begin : g_first
         assign x_d = nx_ff[NORM_STEPS];
         assign y_d = ny_ff[NORM_STEPS];
         assign z_d = '0;
         assign b_d = nb_ff[NORM_STEPS];
      end else begin : g_next
         assign x_d = cx_ff[i-1];
         assign y_d = cy_ff[i-1];
         assign z_d = cz_ff[i-1];
         assign b_d = cb_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            if (!y_d[COR_W-1]) begin
               cx_ff[i] <= x_d + (y_d >>> i);
               cy_ff[i] <= y_d - (x_d >>> i);
               cz_ff[i] <= z_d + ATAN_TABLE[i];
            end else begin
               cx_ff[i] <= x_d - (y_d >>> i);
               cy_ff[i] <= y_d + (x_d >>> i);
               cz_ff[i] <= z_d - ATAN_TABLE[i];
            end
            cb_ff[i] <= b_d;
         end
      end
   end

   // add pi for the fold, then round to nearest output unit
   assign bam_in = {cz_ff[CORDIC_STEPS-1][BAM_W-1] ^ cb_ff[CORDIC_STEPS-1],
                    cz_ff[CORDIC_STEPS-1][BAM_W-2:0]};
   assign rnd_in = bam_in + (BAM_W'(1) << (RND_SH - 1));

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff <= rnd_in[BAM_W-1 -: ANGLE_WIDTH];
      end
   end

   assign angle = angle_ff;

endmodule

>>> rtl/core/cartesian_to_spherical.sv
// Channel   Dir  Beat contents                                  Handshake
// req_*     in   x_coord, y_coord, z_coord (signed)             tvalid/tready
// rsp_*     out  radius, polar_angle, azimuth; status in tuser  tvalid/tready
//
// One point per cycle sustained while rsp is not stalled; rsp_tvalid rises once the req beat
// has passed 81 register stages (input register, 7 front stages, 32 square-root stages, 40
// angle stages, output register). The 32-stage square root and 31 CORDIC stages make up most
// of that depth. Reset is synchronous and clears only the valid/status tags and rsp_tvalid.
// A stall on rsp freezes the whole pipeline in place; req_tready drops that cycle.
module cartesian_to_spherical (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // x_coord[23:0], y_coord[47:24], z_coord[71:48]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // radius[23:0], polar_angle[39:24], azimuth[55:40]
   output logic [1:0]  rsp_tuser   // status[1:0]
);
   import c2s_pkg::*;

   logic advance;

   // input register
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff, z_ff;
   tag_type                       tag0_ff;
   tag_type                       tag0_in;
   logic signed [COORD_WIDTH-1:0] x_in, y_in, z_in;

   // front / square root / angle datapath
   radicand_type sum_sq, scaled_sxy;
   cor_word_type scaled_z;
   root_type     root_theta, root_radius;
   angle_type    theta, phi;

   // alignment delays
   tag_type                  tag_ff    [TOTAL_LAT];
   cor_word_type             zs_dly_ff [SQRT_LAT];
   logic [RADIUS_WIDTH-1:0]  rad_dly_ff [COR_LAT];
   angle_type                phi_dly_ff [FRONT_LAT + SQRT_LAT];

   // output register
   logic                    rsp_valid_ff;
   logic [RADIUS_WIDTH-1:0] radius_ff;
   angle_type               polar_ff, azim_ff;
   status_type              status_ff;

   tag_type tail;
   logic    ok_tail;

   // whole pipeline moves when the output slot is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign x_in = req_tdata[COORD_WIDTH-1:0];
   assign y_in = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign z_in = req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

   always_comb begin
      tag0_in.valid  = req_tvalid;
      tag0_in.status = STAT_OK;
      if (x_in == '0 && y_in == '0) begin
         tag0_in.status = (z_in == '0) ? STAT_ORIGIN : STAT_Z_AXIS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else if (advance) begin
         tag0_ff <= tag0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   // |p|^2 and the prescaled x^2+y^2 for theta
   c2s_front u_front (
      .clock      (clock),
      .advance    (advance),
      .x_coord    (x_ff),
      .y_coord    (y_ff),
      .z_coord    (z_ff),
      .sum_sq     (sum_sq),
      .scaled_sxy (scaled_sxy),
      .scaled_z   (scaled_z)
   );

   c2s_isqrt u_sqrt_radius (
      .clock    (clock),
      .advance  (advance),
      .radicand (sum_sq),
      .root     (root_radius)
   );

   c2s_isqrt u_sqrt_theta (
      .clock    (clock),
      .advance  (advance),
      .radicand (scaled_sxy),
      .root     (root_theta)
   );

   // theta = atan2(sqrt(x^2+y^2), z), both operands scaled by 2^k
   c2s_cordic u_cordic_theta (
      .clock   (clock),
      .advance (advance),
      .num     (COR_W'(root_theta)),
      .den     (zs_dly_ff[SQRT_LAT-1]),
      .angle   (theta)
   );

   // phi starts straight off the input register, then waits in phi_dly
   c2s_cordic u_cordic_phi (
      .clock   (clock),
      .advance (advance),
      .num     (COR_W'(y_ff)),
      .den     (COR_W'(x_ff)),
      .angle   (phi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TOTAL_LAT; k++) begin
            tag_ff[k] <= '0;
         end
      end else if (advance) begin
         tag_ff[0] <= tag0_ff;
         for (int k = 1; k < TOTAL_LAT; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zs_dly_ff[0] <= scaled_z;
         for (int k = 1; k < SQRT_LAT; k++) begin
            zs_dly_ff[k] <= zs_dly_ff[k-1];
         end
         rad_dly_ff[0] <= root_radius[RADIUS_WIDTH-1:0];
         for (int k = 1; k < COR_LAT; k++) begin
            rad_dly_ff[k] <= rad_dly_ff[k-1];
         end
         phi_dly_ff[0] <= phi;
         for (int k = 1; k < FRONT_LAT + SQRT_LAT; k++) begin
            phi_dly_ff[k] <= phi_dly_ff[k-1];
         end
      end
   end

   assign tail    = tag_ff[TOTAL_LAT-1];
   assign ok_tail = (tail.status == STAT_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid;
      end
   end

   // axis and origin points report zero angles
   always_ff @(posedge clock) begin
      if (advance) begin
         radius_ff <= rad_dly_ff[COR_LAT-1];
         polar_ff  <= ok_tail ? theta : '0;
         azim_ff   <= ok_tail ? phi_dly_ff[FRONT_LAT + SQRT_LAT - 1] : '0;
         status_ff <= tail.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {azim_ff, polar_ff, radius_ff};
   assign rsp_tuser  = status_ff;

   a_axis_angles_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_OK) |-> (rsp_tdata[55:24] == '0))
      else $error("nonzero angle on axis or origin beat");

   a_origin_radius_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_ORIGIN) |-> (rsp_tdata[23:0] == '0))
      else $error("origin beat with nonzero radius");

   a_zaxis_radius_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_Z_AXIS) |-> (rsp_tdata[23:0] != '0))
      else $error("z-axis beat with zero radius");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(tail) && $stable(tag0_ff))
      else $error("pipeline moved during stall");

endmodule

>>> tb/c2s_checker.sv
`timescale 1ns / 100ps

module c2s_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count
);
   import c2s_pkg::*;

   typedef struct packed {
      logic [23:0] radius;
      angle_type   polar;
      angle_type   azim;
      status_type  status;
   } sph_point_type;

   sph_point_type pending_q[$];

   localparam logic [31:0] ATAN_BAM [31] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
      32'd1
   };

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // vectoring CORDIC, 2^32 units per turn
   function automatic logic [31:0] bam_atan2(logic signed [63:0] yy, logic signed [63:0] xx);
      logic [31:0]        base;
      logic signed [63:0] x, y, acc, dx, dy;
      logic [63:0]        m;
      base = 0;
      x = xx;
      y = yy;
      acc = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         base = 32'h8000_0000;
      end
      m = (abs64(x) > abs64(y)) ? abs64(x) : abs64(y);
      while (m >= (64'd1 << 59)) begin
         x = x >>> 1;
         y = y >>> 1;
         m = m >> 1;
      end
      while (m < (64'd1 << 58)) begin
         x = x * 2;
         y = y * 2;
         m = m * 2;
      end
      for (int i = 0; i < 31; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            acc = acc + ATAN_BAM[i];
         end else begin
            x = x - dx;
            y = y + dy;
            acc = acc - ATAN_BAM[i];
         end
      end
      return base + acc[31:0];
   endfunction

   function automatic angle_type round_angle(logic [31:0] a);
      logic [32:0] v;
      v = {1'b0, a} + (33'd1 << 15);
      return v[31:16];
   endfunction

   function automatic sph_point_type to_spherical(logic [71:0] d);
      sph_point_type      p;
      logic signed [63:0] x, y, z, zs;
      logic [63:0]        sxy, s, root;
      x = {{40{d[23]}}, d[23:0]};
      y = {{40{d[47]}}, d[47:24]};
      z = {{40{d[71]}}, d[71:48]};
      sxy = abs64(x) * abs64(x) + abs64(y) * abs64(y);
      root = int_sqrt(sxy + abs64(z) * abs64(z));
      p.radius = (root > 64'hFF_FFFF) ? 24'hFF_FFFF : root[23:0];
      p.polar = '0;
      p.azim = '0;
      if (sxy == 0) begin
         p.status = (z == 0) ? STAT_ORIGIN : STAT_Z_AXIS;
      end else begin
         s = sxy;
         zs = z;
         while (s < (64'd1 << 62)) begin
            s = s << 2;
            zs = zs * 2;
         end
         p.polar = round_angle(bam_atan2(int_sqrt(s), zs));
         p.azim = round_angle(bam_atan2(y, x));
         p.status = STAT_OK;
      end
      return p;
   endfunction

   initial pending_count = 0;

   always @(posedge clock) begin
      sph_point_type exp_p, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) pending_q.push_back(to_spherical(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[23:0], rsp_tdata[39:24], rsp_tdata[55:40],
                   status_type'(rsp_tuser)};
            if (pending_q.size() == 0) begin
               $display("%0t: unexpected beat, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_p = pending_q.pop_front();
               if (got !== exp_p) begin
                  $display({"%0t: mismatch expected r=%0d th=%0d ph=%0d st=%0d,",
                            " actual r=%0d th=%0d ph=%0d st=%0d"},
                     $time, exp_p.radius, exp_p.polar, $signed(exp_p.azim), exp_p.status,
                     got.radius, got.polar, $signed(got.azim), got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= pending_q.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import c2s_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // x[23:0], y[47:24], z[71:48]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;        // radius[23:0], polar[39:24], azimuth[55:40]
   logic [1:0]  rsp_tuser;        // status[1:0]
   int          fail_count, pending_count;
   int          idle_pct = 0;     // sender idle, percent
   int          stall_pct = 0;    // receiver stall, percent
   longint      cycle_count = 0;

   localparam longint CYCLE_LIMIT = 400000;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   cartesian_to_spherical DUT (.*);

   c2s_checker u_checker (.*);

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver stalls at random, rate set per phase
   always @(negedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(5))
         0: return 24'(24'h80_0000 + $urandom_range(3));
         1: return 24'(24'h7F_FFFF - $urandom_range(3));
         2: return 24'($urandom_range(8) - 4);
         3: return 24'($urandom_range(600) - 300);
         default: return 24'($urandom);
      endcase
   endfunction

   // one beat: present at falling edge, hold until taken
   task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tdata <= {z, y, x};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   initial begin
      logic [23:0] ex, ey, ez;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: origin, z axis both signs, axis extremes, azimuth at pi
      send_point(0, 0, 0);
      send_point(0, 0, 24'd5);
      send_point(0, 0, 24'h80_0000);
      send_point(0, 0, 24'h7F_FFFF);
      send_point(24'h80_0000, 24'h80_0000, 24'h80_0000);
      send_point(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
      send_point(24'h80_0000, 0, 0);      // phi = pi
      send_point(24'hFF_FFFF, 0, 24'd1);  // phi = pi, small
      send_point(24'h7F_FFFF, 0, 0);
      send_point(0, 24'h7F_FFFF, 0);
      send_point(0, 24'h80_0000, 0);
      send_point(24'd1, 0, 24'h80_0000);  // theta near pi
      send_point(24'd1, 24'd1, 24'd1);
      send_point(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
      send_point(24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFF);
      send_point(24'd3, 24'hFF_FFFC, 24'h7F_FFFF);
      send_point(24'h55_5555, 24'hAA_AAAA, 24'h33_3333);
      drain();

      // random phases: free, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 87 : (ph == 3) ? 14 : 0;
         stall_pct = (ph == 2) ? 87 : (ph == 3) ? 14 : 0;
         for (int n = 0; n < 100; n++) begin
            ex = rand_coord();
            ey = rand_coord();
            ez = rand_coord();
            if ($urandom_range(15) == 0) begin
               ex = 0;
               ey = 0;
            end
            send_point(ex, ey, ez);
         end
      end
      drain();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
